@@ rtl/gcpe_pkg.sv @@
// ----------------------------------------------------------------------------
// gcpe_pkg
// Shared constants, types and exponential tables for the Gaussian cohesive
// potential evaluator.
// ----------------------------------------------------------------------------
package gcpe_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int WHOLE_STEPS     = 32;
    localparam int WHOLE_BITS      = $clog2(WHOLE_STEPS);

    localparam int W_BITS     = 32;                      // data word
    localparam int B_BITS     = 31;                      // width register
    localparam int FUNC_BITS  = 2;
    localparam int UD_BITS    = 32;                      // |x - l0|
    localparam int DL_BITS    = W_BITS + 1;
    localparam int SQ_BITS    = 2 * UD_BITS;
    localparam int M1_BITS    = W_BITS + UD_BITS - FRAC_BITS;
    localparam int T_BITS     = FRAC_BITS + WHOLE_BITS;  // useful range of t
    localparam int REM_BITS   = T_BITS + B_BITS;
    localparam int DIV_STAGES = T_BITS + 1;
    localparam int Q30_SHIFT  = 30;
    localparam int Q30_BITS   = Q30_SHIFT + 1;
    localparam int IDX_BITS   = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int P_BITS     = FRAC_BITS + IDX_BITS;
    localparam int K_BITS     = T_BITS + 2;
    localparam int X_BITS     = W_BITS + B_BITS - 1;
    localparam int Y_BITS     = 32;
    localparam int PPL_BITS   = 64;
    localparam int PPH_BITS   = X_BITS - 32 + Y_BITS;
    localparam int PROD_BITS  = X_BITS + Y_BITS;
    localparam int MAG_BITS   = 63;

    localparam int SHIFT_HALF = FRAC_BITS + 1;
    localparam int SHIFT_AB   = FRAC_BITS + B_BITS;

    localparam logic [63:0] ONE30 = 64'd1 << Q30_SHIFT;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STIFF = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REST  = 2'd2;

    localparam logic [W_BITS-1:0] STIFF_RST = 32'h0001_0000;
    localparam logic [B_BITS-1:0] WIDTH_RST = 31'h0001_0000;
    localparam logic [W_BITS-1:0] REST_RST  = 32'h0000_0000;

    localparam logic [FUNC_BITS-1:0] FUNC_POT  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_D1   = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_D2   = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_NONE = 2'd3;

    // final scaling of the shared product
    typedef logic [2:0] t_sel;
    localparam t_sel SEL_NONE = 3'd0;
    localparam t_sel SEL_FRAC = 3'd1;
    localparam t_sel SEL_HALF = 3'd2;
    localparam t_sel SEL_Q30  = 3'd3;
    localparam t_sel SEL_AB   = 3'd4;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 dpos;
        logic [UD_BITS-1:0]   ud;
        logic [M1_BITS-1:0]   m1;
    } t_side;

    typedef logic [Q30_BITS-1:0] t_frac_rom [EXP_TABLE_DEPTH+1];
    typedef logic [Q30_BITS-1:0] t_whole_rom [WHOLE_STEPS];

    // exp(-x), x in [0,1], Q30 in and out, alternating series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum  = $signed(ONE30);
        term = ONE30;
        for (int k = 1; k <= 30; k++) begin
            if (term != 64'd0) begin
                term = ((term * x) >> Q30_SHIFT) / 64'(k);
                if (k[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
        end
        return (sum < 0) ? 64'd0 : $unsigned(sum);
    endfunction

    function automatic t_frac_rom build_frac_rom();
        t_frac_rom rom;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            rom[i] = Q30_BITS'(exp_neg_q30((64'(i) << Q30_SHIFT) / 64'(EXP_TABLE_DEPTH)));
        end
        return rom;
    endfunction

    function automatic t_whole_rom build_whole_rom();
        t_whole_rom  rom;
        logic [63:0] e1;
        logic [63:0] w;
        e1 = exp_neg_q30(ONE30);
        w  = ONE30;
        for (int i = 0; i < WHOLE_STEPS; i++) begin
            rom[i] = Q30_BITS'(w);
            w      = (w * e1) >> Q30_SHIFT;
        end
        return rom;
    endfunction

    localparam t_frac_rom  FRAC_ROM  = build_frac_rom();
    localparam t_whole_rom WHOLE_ROM = build_whole_rom();

endpackage

@@ rtl/gcpe_if.sv @@
// ----------------------------------------------------------------------------
// gcpe channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface gcpe_in_if;
    import gcpe_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [FUNC_BITS-1:0]        func;
    logic signed [W_BITS-1:0]    stretch;
    modport source (output valid, func, stretch, input ready);
    modport sink   (input valid, func, stretch, output ready);
endinterface

interface gcpe_out_if;
    import gcpe_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [W_BITS-1:0]    value;
    logic                        overflow;
    modport source (output valid, value, overflow, input ready);
    modport sink   (input valid, value, overflow, output ready);
endinterface

interface gcpe_cfg_if;
    import gcpe_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [CFG_IDX_BITS-1:0]     index;
    logic [W_BITS-1:0]           data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/gaussian_cohesive_potential_eval.sv @@
// ----------------------------------------------------------------------------
// gaussian_cohesive_potential_eval
// Quadratic / Gaussian-softened cohesive law: potential, first or second
// derivative of dl = x - l0, saturated to 32 bits.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the output stalls; the 22-stage divider
// for dl^2/B sets depth. Each stage holds its item until the next one frees,
// so bubbles close up. Reset (synchronous, active low) empties the pipeline
// and loads A = 1.0, B = 1.0, l0 = 0. Register writes are always accepted.
module gaussian_cohesive_potential_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gcpe_in_if.sink      i_in,
    gcpe_out_if.source   o_out,
    gcpe_cfg_if.sink     i_cfg
);
    import gcpe_pkg::*;

    // configuration
    logic signed [W_BITS-1:0] r_stiff;
    logic [B_BITS-1:0]        r_width;
    logic signed [W_BITS-1:0] r_rest;
    logic [W_BITS-1:0]        abs_a;
    logic                     a_neg;
    logic [B_BITS-1:0]        b_eff;

    // stage enables
    logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en_out;
    logic div_rdy, div_vld, div_big;
    logic [T_BITS-1:0] div_quot;
    t_side div_side;

    // stage 1: difference
    logic r_v1;
    logic [FUNC_BITS-1:0] r_func1;
    logic r_dpos1;
    logic [UD_BITS-1:0] r_ud1;
    logic [DL_BITS-1:0] n_dl;

    // stage 2: square and A*|dl|
    logic r_v2;
    logic [FUNC_BITS-1:0] r_func2;
    logic r_dpos2;
    logic [UD_BITS-1:0] r_ud2;
    logic [SQ_BITS-1:0] r_sq2;
    logic [M1_BITS-1:0] r_m1_2;
    logic [2*W_BITS-1:0] n_am;

    // stage 3: table lookup
    logic r_v3, r_big3;
    logic [T_BITS-1:0] r_t3;
    t_side r_side3;
    logic [Q30_BITS-1:0] r_a3, r_d3, r_w3;
    logic [FRAC_BITS-1:0] r_fr3;
    logic [P_BITS-1:0] n_p;
    logic [IDX_BITS-1:0] n_idx;
    logic [Q30_BITS-1:0] n_ra, n_rb;

    // stage 4: interpolation
    logic r_v4, r_big4;
    logic [T_BITS-1:0] r_t4;
    t_side r_side4;
    logic [Q30_BITS-1:0] r_ef4, r_w4;
    logic [Q30_BITS+FRAC_BITS-1:0] n_df;

    // stage 5: scale by exp(-n)
    logic r_v5;
    logic [T_BITS-1:0] r_t5;
    t_side r_side5;
    logic [Q30_BITS-1:0] r_e5;
    logic [2*Q30_BITS-1:0] n_ew;

    // stage 6: |A| times B or e, and 1 - 2t
    logic r_v6;
    t_side r_side6;
    logic [Q30_BITS-1:0] r_e6;
    logic [X_BITS-1:0] r_pre6;
    logic [K_BITS-1:0] r_absk6;
    logic r_kneg6;
    logic [B_BITS-1:0] n_z;
    logic [W_BITS+B_BITS-1:0] n_pre;
    logic [K_BITS-1:0] n_k;

    // stage 7: partial products
    logic r_v7, r_neg7;
    t_sel r_sel7;
    logic [PPL_BITS-1:0] r_ppl7;
    logic [PPH_BITS-1:0] r_pph7;
    logic [X_BITS-1:0] n_x;
    logic [Y_BITS-1:0] n_y;
    t_sel n_sel;
    logic n_neg;

    // stage 8: product sum
    logic r_v8, r_neg8;
    t_sel r_sel8;
    logic [PROD_BITS-1:0] r_prod8;

    // stage 9: scaling
    logic r_v9, r_neg9;
    logic [MAG_BITS-1:0] r_mag9;
    logic [MAG_BITS-1:0] n_mag;

    // output
    logic r_vo, r_ovf;
    logic [W_BITS-1:0] r_value;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= STIFF_RST;
            r_width <= WIDTH_RST;
            r_rest  <= REST_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STIFF: r_stiff <= i_cfg.data;
                REG_WIDTH: r_width <= i_cfg.data[B_BITS-1:0];
                REG_REST:  r_rest  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign a_neg = r_stiff[W_BITS-1];
    assign abs_a = a_neg ? $unsigned(-r_stiff) : $unsigned(r_stiff);
    assign b_eff = (r_width == '0) ? B_BITS'(1) : r_width;

    // ---------------- enables ----------------
    assign en_out = !r_vo || o_out.ready;
    assign en9    = !r_v9 || en_out;
    assign en8    = !r_v8 || en9;
    assign en7    = !r_v7 || en8;
    assign en6    = !r_v6 || en7;
    assign en5    = !r_v5 || en6;
    assign en4    = !r_v4 || en5;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || div_rdy;
    assign en1    = !r_v1 || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
            r_v9 <= 1'b0; r_vo <= 1'b0;
        end else begin
            if (en1)    r_v1 <= i_in.valid;
            if (en2)    r_v2 <= r_v1;
            if (en3)    r_v3 <= div_vld;
            if (en4)    r_v4 <= r_v3;
            if (en5)    r_v5 <= r_v4;
            if (en6)    r_v6 <= r_v5;
            if (en7)    r_v7 <= r_v6;
            if (en8)    r_v8 <= r_v7;
            if (en9)    r_v9 <= r_v8;
            if (en_out) r_vo <= r_v9;
        end
    end

    // ---------------- stage 1 ----------------
    assign n_dl = {i_in.stretch[W_BITS-1], i_in.stretch} - {r_rest[W_BITS-1], r_rest};

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_func1 <= i_in.func;
            r_dpos1 <= !n_dl[DL_BITS-1] && (n_dl != '0);
            r_ud1   <= n_dl[DL_BITS-1] ? UD_BITS'(~n_dl + DL_BITS'(1)) : n_dl[UD_BITS-1:0];
        end
    end

    // ---------------- stage 2 ----------------
    assign n_am = (2*W_BITS)'(abs_a) * (2*W_BITS)'(r_ud1);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_func2 <= r_func1;
            r_dpos2 <= r_dpos1;
            r_ud2   <= r_ud1;
            r_sq2   <= SQ_BITS'(r_ud1) * SQ_BITS'(r_ud1);
            r_m1_2  <= n_am[FRAC_BITS +: M1_BITS];
        end
    end

    // ---------------- divider ----------------
    gcpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v2),
        .o_rdy   (div_rdy),
        .i_num   (r_sq2),
        .i_den   (b_eff),
        .i_side  ('{func: r_func2, dpos: r_dpos2, ud: r_ud2, m1: r_m1_2}),
        .o_vld   (div_vld),
        .i_rdy   (en3),
        .o_quot  (div_quot),
        .o_big   (div_big),
        .o_side  (div_side)
    );

    // ---------------- stage 3 ----------------
    assign n_p   = P_BITS'(div_quot[FRAC_BITS-1:0]) * P_BITS'(EXP_TABLE_DEPTH);
    assign n_idx = n_p[P_BITS-1:FRAC_BITS];
    assign n_ra  = FRAC_ROM[n_idx];
    assign n_rb  = FRAC_ROM[n_idx + IDX_BITS'(1)];

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_big3  <= div_big;
            r_t3    <= div_quot;
            r_side3 <= div_side;
            r_a3    <= n_ra;
            r_d3    <= (n_ra > n_rb) ? (n_ra - n_rb) : '0;
            r_fr3   <= n_p[FRAC_BITS-1:0];
            r_w3    <= WHOLE_ROM[div_quot[T_BITS-1:FRAC_BITS]];
        end
    end

    // ---------------- stage 4 ----------------
    assign n_df = (Q30_BITS+FRAC_BITS)'(r_d3) * (Q30_BITS+FRAC_BITS)'(r_fr3);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_big4  <= r_big3;
            r_t4    <= r_t3;
            r_side4 <= r_side3;
            r_ef4   <= r_a3 - n_df[FRAC_BITS +: Q30_BITS];
            r_w4    <= r_w3;
        end
    end

    // ---------------- stage 5 ----------------
    assign n_ew = (2*Q30_BITS)'(r_ef4) * (2*Q30_BITS)'(r_w4);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_t5    <= r_t4;
            r_side5 <= r_side4;
            r_e5    <= r_big4 ? '0 : n_ew[Q30_SHIFT +: Q30_BITS];
        end
    end

    // ---------------- stage 6 ----------------
    assign n_z   = (r_side5.func == FUNC_POT && r_side5.dpos) ? b_eff : r_e5;
    assign n_pre = (W_BITS+B_BITS)'(abs_a) * (W_BITS+B_BITS)'(n_z);
    assign n_k   = (K_BITS'(1) << FRAC_BITS) - {1'b0, r_t5, 1'b0};

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_side6 <= r_side5;
            r_e6    <= r_e5;
            r_pre6  <= n_pre[X_BITS-1:0];
            r_kneg6 <= n_k[K_BITS-1];
            r_absk6 <= n_k[K_BITS-1] ? (~n_k + K_BITS'(1)) : n_k;
        end
    end

    // ---------------- stage 7 ----------------
    always_comb begin
        n_x   = '0;
        n_y   = '0;
        n_sel = SEL_NONE;
        n_neg = 1'b0;
        case (r_side6.func)
            FUNC_POT: begin
                n_neg = a_neg;
                if (r_side6.dpos) begin
                    n_x   = r_pre6;
                    n_y   = Y_BITS'(ONE30) - Y_BITS'(r_e6);
                    n_sel = SEL_AB;
                end else begin
                    n_x   = X_BITS'(r_side6.m1);
                    n_y   = Y_BITS'(r_side6.ud);
                    n_sel = SEL_HALF;
                end
            end
            FUNC_D1: begin
                n_x = X_BITS'(r_side6.m1);
                if (r_side6.dpos) begin
                    n_y   = Y_BITS'(r_e6);
                    n_sel = SEL_Q30;
                    n_neg = a_neg;
                end else begin
                    n_y   = Y_BITS'(1);
                    n_neg = !a_neg;
                end
            end
            FUNC_D2: begin
                if (r_side6.dpos) begin
                    // |1 - 2t| times |A*e|; a zero e gives a zero product
                    n_x   = X_BITS'(r_absk6);
                    n_y   = r_pre6[Q30_SHIFT +: Y_BITS];
                    n_sel = SEL_FRAC;
                    n_neg = r_kneg6 ^ a_neg;
                end else begin
                    n_x   = X_BITS'(abs_a);
                    n_y   = Y_BITS'(1);
                    n_neg = a_neg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r_neg7 <= n_neg;
            r_sel7 <= n_sel;
            r_ppl7 <= PPL_BITS'(n_x[31:0]) * PPL_BITS'(n_y);
            r_pph7 <= PPH_BITS'(n_x[X_BITS-1:32]) * PPH_BITS'(n_y);
        end
    end

    // ---------------- stage 8 ----------------
    always_ff @(posedge i_clk) begin
        if (en8) begin
            r_neg8  <= r_neg7;
            r_sel8  <= r_sel7;
            r_prod8 <= (PROD_BITS'(r_pph7) << 32) + PROD_BITS'(r_ppl7);
        end
    end

    // ---------------- stage 9 ----------------
    always_comb begin
        case (r_sel8)
            SEL_FRAC: n_mag = MAG_BITS'(r_prod8 >> FRAC_BITS);
            SEL_HALF: n_mag = MAG_BITS'(r_prod8 >> SHIFT_HALF);
            SEL_Q30:  n_mag = MAG_BITS'(r_prod8 >> Q30_SHIFT);
            SEL_AB:   n_mag = MAG_BITS'(r_prod8 >> SHIFT_AB);
            default:  n_mag = MAG_BITS'(r_prod8);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en9) begin
            r_neg9 <= r_neg8;
            r_mag9 <= n_mag;
        end
    end

    // ---------------- saturation / output ----------------
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            if (r_neg9) begin
                if (r_mag9 > (MAG_BITS'(1) << (W_BITS - 1))) begin
                    r_value <= W_BITS'(1) << (W_BITS - 1);
                    r_ovf   <= 1'b1;
                end else begin
                    r_value <= ~r_mag9[W_BITS-1:0] + W_BITS'(1);
                    r_ovf   <= 1'b0;
                end
            end else begin
                if (r_mag9 > MAG_BITS'({(W_BITS-1){1'b1}})) begin
                    r_value <= {1'b0, {(W_BITS-1){1'b1}}};
                    r_ovf   <= 1'b1;
                end else begin
                    r_value <= r_mag9[W_BITS-1:0];
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid    = r_vo;
    assign o_out.value    = r_value;
    assign o_out.overflow = r_ovf;

`ifndef SYNTHESIS
    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_ovf |-> (r_value == 32'h7fff_ffff || r_value == 32'h8000_0000))
        else $error("overflow flagged on an unsaturated value");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_e5 <= Q30_BITS'(ONE30)))
        else $error("exponential above one");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v9 |-> (r_mag9 < (MAG_BITS'(1) << 62)))
        else $error("result magnitude out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v9 && !en9 |=> r_v9 && $stable(r_mag9))
        else $error("stalled stage lost its item");
`endif

endmodule

@@ rtl/gcpe_div.sv @@
// ----------------------------------------------------------------------------
// gcpe_div
// Pipelined restoring divider for t = dl^2 / B, one quotient bit per stage.
// Quotients at or above 2^T_BITS are only flagged as big.
// ----------------------------------------------------------------------------
module gcpe_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    output logic                           o_rdy,
    input  logic [gcpe_pkg::SQ_BITS-1:0]   i_num,
    input  logic [gcpe_pkg::B_BITS-1:0]    i_den,
    input  gcpe_pkg::t_side                i_side,
    output logic                           o_vld,
    input  logic                           i_rdy,
    output logic [gcpe_pkg::T_BITS-1:0]    o_quot,
    output logic                           o_big,
    output gcpe_pkg::t_side                o_side
);
    import gcpe_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [DIV_STAGES-1:0] en;
    logic [DIV_STAGES-1:0] r_big;
    logic [REM_BITS-1:0]   r_rem  [DIV_STAGES];
    logic [T_BITS-1:0]     r_quot [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];
    logic [REM_BITS-1:0]   n_rem  [1:DIV_STAGES-1];
    logic [T_BITS-1:0]     n_quot [1:DIV_STAGES-1];
    logic [SQ_BITS-1:0]    den_top;
    logic                  n_big;

    assign den_top = SQ_BITS'({i_den, {T_BITS{1'b0}}});
    assign n_big   = (i_num >= den_top);

    always_comb begin
        en[DIV_STAGES-1] = !r_vld[DIV_STAGES-1] || i_rdy;
        for (int j = DIV_STAGES - 2; j >= 0; j--) begin
            en[j] = !r_vld[j] || en[j+1];
        end
    end

    always_comb begin
        logic [REM_BITS-1:0] trial;
        for (int j = 1; j < DIV_STAGES; j++) begin
            trial = REM_BITS'(i_den) << (T_BITS - j);
            if (r_rem[j-1] >= trial) begin
                n_rem[j]  = r_rem[j-1] - trial;
                n_quot[j] = r_quot[j-1] | (T_BITS'(1) << (T_BITS - j));
            end else begin
                n_rem[j]  = r_rem[j-1];
                n_quot[j] = r_quot[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int j = 1; j < DIV_STAGES; j++) begin
                if (en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    // remainder stays below B * 2^T_BITS whenever big is clear
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_big[0]  <= n_big;
            r_rem[0]  <= i_num[REM_BITS-1:0];
            r_quot[0] <= '0;
            r_side[0] <= i_side;
        end
        for (int j = 1; j < DIV_STAGES; j++) begin
            if (en[j]) begin
                r_big[j]  <= r_big[j-1];
                r_rem[j]  <= n_rem[j];
                r_quot[j] <= n_quot[j];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_rdy  = en[0];
    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_quot = r_quot[DIV_STAGES-1];
    assign o_big  = r_big[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

@@ tb/gaussian_cohesive_potential_eval_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_cohesive_potential_eval_test
// Self-checking bench for the Gaussian cohesive potential evaluator. A local
// fixed-point predictor computes every result; random idles on both channels;
// register settings are swept between phases, extremes included.
// ----------------------------------------------------------------------------
module gaussian_cohesive_potential_eval_test;
    import gcpe_pkg::*;

    localparam int          SETTLE_CYCLES = 40;
    localparam logic [63:0] Q30_ONE       = 64'd1 << 30;
    localparam logic [127:0] MAG_LIMIT    = 128'd1 << 62;
    // register index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [31:0] value;
        logic        overflow;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    gcpe_in_if  in_ch ();
    gcpe_out_if out_ch ();
    gcpe_cfg_if cfg_ch ();

    gaussian_cohesive_potential_eval i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // predictor copy of the registers and exponential tables
    longint      stiff_a;
    logic [63:0] width_reg;
    longint      rest_len;
    logic [63:0] exp_frac_tab [EXP_TABLE_DEPTH+1];
    logic [63:0] exp_whole_tab [32];

    t_result pending_results [$];
    int      n_fail;
    int      n_sent;
    int      n_checked;
    int      n_ovf;
    int      n_cfg;
    logic    no_idle;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // exp(-x), x in [0,1], Q30 in and out
    function automatic logic [63:0] exp_series(logic [63:0] x);
        longint      sum;
        logic [63:0] term;
        sum  = longint'(Q30_ONE);
        term = Q30_ONE;
        for (int k = 1; k <= 30; k++) begin
            if (term != 0) begin
                term = ((term * x) >> 30) / 64'(k);
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    task automatic fill_exp_tables();
        logic [63:0] e1;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            exp_frac_tab[i] = exp_series((64'(i) << 30) / 64'(EXP_TABLE_DEPTH));
        end
        e1 = exp_series(Q30_ONE);
        exp_whole_tab[0] = Q30_ONE;
        for (int i = 1; i < 32; i++) begin
            exp_whole_tab[i] = (exp_whole_tab[i-1] * e1) >> 30;
        end
    endtask

    // a*b >> s, truncated toward zero, magnitude clamped at 2^62
    function automatic longint scaled_mul(longint a, logic [63:0] b, int s);
        logic [63:0]  ma;
        logic [127:0] r;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        r  = ({64'd0, ma} * {64'd0, b}) >> s;
        if (r > MAG_LIMIT) begin
            r = MAG_LIMIT;
        end
        return (a < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    // exp(-t), t unsigned with FRAC_BITS fraction bits, Q30 result
    function automatic logic [63:0] exp_neg_fixed(logic [63:0] t);
        logic [63:0] whole_part, p, idx, fr, lo, hi, d, ef;
        logic [63:0] fmask;
        fmask      = (64'd1 << FRAC_BITS) - 1;
        whole_part = t >> FRAC_BITS;
        if (whole_part >= 32) begin
            return 64'd0;
        end
        p   = (t & fmask) * 64'(EXP_TABLE_DEPTH);
        idx = p >> FRAC_BITS;
        fr  = p & fmask;
        lo  = exp_frac_tab[idx];
        hi  = exp_frac_tab[idx+1];
        d   = (lo > hi) ? lo - hi : 64'd0;
        ef  = lo - ((d * fr) >> FRAC_BITS);
        return (ef * exp_whole_tab[whole_part]) >> 30;
    endfunction

    function automatic t_result potential_of(logic [FUNC_BITS-1:0] fn, logic [31:0] xs);
        t_result     res;
        longint      x, dl, r, ae, k;
        logic [63:0] ud, b, t, e, mae;
        x   = longint'($signed(xs));
        b   = (width_reg == 0) ? 64'd1 : width_reg;
        dl  = x - rest_len;
        ud  = (dl < 0) ? 64'(-dl) : 64'(dl);
        r   = 0;
        res.value    = '0;
        res.overflow = 1'b0;
        if (fn == FUNC_NONE) begin
            return res;
        end
        if (dl <= 0) begin
            // compressive side: plain quadratic law
            if (fn == FUNC_POT) begin
                r = scaled_mul(scaled_mul(stiff_a, ud, FRAC_BITS), ud, FRAC_BITS + 1);
            end else if (fn == FUNC_D1) begin
                r = -scaled_mul(stiff_a, ud, FRAC_BITS);
            end else begin
                r = stiff_a;
            end
        end else begin
            t = (ud * ud) / b;
            e = exp_neg_fixed(t);
            if (fn == FUNC_POT) begin
                r = scaled_mul(stiff_a * longint'(b), Q30_ONE - e, FRAC_BITS + 31);
            end else if (fn == FUNC_D1) begin
                r = scaled_mul(scaled_mul(stiff_a, ud, FRAC_BITS), e, 30);
            end else if (e != 0) begin
                ae  = scaled_mul(stiff_a, e, 30);
                k   = (longint'(1) << FRAC_BITS) - 2 * longint'(t);
                mae = (ae < 0) ? 64'(-ae) : 64'(ae);
                r   = scaled_mul(k, mae, FRAC_BITS);
                if (ae < 0) begin
                    r = -r;
                end
            end
        end
        if (r > longint'(32'h7fff_ffff)) begin
            r = 32'h7fff_ffff;
            res.overflow = 1'b1;
        end else if (r < -longint'(64'h8000_0000)) begin
            r = -longint'(64'h8000_0000);
            res.overflow = 1'b1;
        end
        res.value = r[31:0];
        return res;
    endfunction

    task automatic send_item(logic [FUNC_BITS-1:0] fn, logic [31:0] xs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= fn;
        in_ch.stretch <= xs;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(potential_of(fn, xs));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_STIFF: stiff_a   = longint'($signed(data));
            REG_WIDTH: width_reg = {33'd0, data[30:0]};
            REG_REST:  rest_len  = longint'($signed(data));
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_law(logic [31:0] a, logic [31:0] b, logic [31:0] l0);
        wait_idle();
        write_reg(REG_STIFF, a);
        write_reg(REG_WIDTH, b);
        write_reg(REG_REST, l0);
    endtask

    // mostly stretches near the rest length, where the softened branch lives
    function automatic logic [31:0] pick_stretch();
        int mode;
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
            return $urandom;
        end else if (mode == 1) begin
            return 32'(rest_len) + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        end
        return 32'(rest_len) + 32'($urandom_range(0, 32'h0100_0000)) - 32'h0040_0000;
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_item(FUNC_BITS'($urandom_range(0, 3)), pick_stretch());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_directed();
        logic [31:0] xs [6];
        xs = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h0001_8000};
        foreach (xs[i]) begin
            send_item(FUNC_POT, xs[i]);
            send_item(FUNC_D1, xs[i]);
            send_item(FUNC_D2, xs[i]);
        end
        send_item(FUNC_NONE, 32'h0002_0000);
        // zero width is treated as the smallest positive width
        set_law(32'h0001_0000, 32'h0, 32'h0);
        send_item(FUNC_POT, 32'h0000_0001);
        send_item(FUNC_D1, 32'h0000_0001);
        send_item(FUNC_D2, 32'h0);
        // difference wider than 32 bits in both directions
        set_law(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_item(FUNC_D1, 32'h7fff_ffff);
        send_item(FUNC_POT, 32'h7fff_ffff);
        set_law(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff);
        send_item(FUNC_POT, 32'h8000_0000);
        send_item(FUNC_D1, 32'h8000_0000);
        send_item(FUNC_D2, 32'h8000_0000);
    endtask

    task automatic test_config_sweep();
        set_law(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        random_burst(120);
        set_law(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff);
        random_burst(120);
        set_law(32'hfffe_0000, 32'h0000_4000, 32'h0003_0000);
        random_burst(120);
        // unused register index must leave the law untouched
        wait_idle();
        write_reg(REG_SPARE, $urandom);
        random_burst(40);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            set_law($urandom, $urandom_range(1, 32'h0010_0000), $urandom);
            random_burst(60);
            if (phase == 3) begin
                // let the pipeline drain completely before carrying on
                in_ch.valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            random_burst(60);
        end
        set_law(32'h0001_0000, 32'h0001_0000, 32'h0);
        random_burst(200);
    endtask

    // result check
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%h overflow=%b", $realtime,
                         out_ch.value, out_ch.overflow);
                n_fail++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (exp_res.overflow) n_ovf++;
                if (out_ch.value !== exp_res.value) begin
                    $display("%0t: value mismatch expected=%h actual=%h", $realtime,
                             exp_res.value, out_ch.value);
                    n_fail++;
                end
                if (out_ch.overflow !== exp_res.overflow) begin
                    $display("%0t: overflow mismatch expected=%b actual=%b", $realtime,
                             exp_res.overflow, out_ch.overflow);
                    n_fail++;
                end
            end
        end
    end

    // result-side back-pressure
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && i_rst_n));
            @(negedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        n_fail = 0;
        n_sent = 0;
        n_checked = 0;
        n_ovf = 0;
        n_cfg = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_POT;
        in_ch.stretch = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_STIFF;
        cfg_ch.data = '0;
        stiff_a = longint'($signed(STIFF_RST));
        width_reg = 64'(WIDTH_RST);
        rest_len = longint'($signed(REST_RST));
        fill_exp_tables();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_config_sweep();
        test_random();

        wait_idle();
        $display("Sent %0d items, checked %0d results (%0d saturated), %0d register writes.",
                 n_sent, n_checked, n_ovf, n_cfg);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
